/* rtl/binary_to_decimal_ascii_formatter_macros.svh */
// Assertion macros for the decimal ASCII formatter.
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BDAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdaf: same-cycle property violated");

// Antecedent implies consequent in the next cycle.
`define BDAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdaf: next-cycle property violated");

`endif

/* rtl/bdaf_pkg.sv */
// Types, constants and helper functions shared by the decimal ASCII formatter.
`default_nettype none
package bdaf_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int BCD_DIGITS  = 5;
   localparam int BCD_WIDTH   = 4 * BCD_DIGITS;
   localparam int CHAR_WIDTH  = 6;
   localparam int MAX_CHARS   = 6;
   localparam int CMD_WIDTH   = 3;
   localparam int COUNT_WIDTH = $clog2(MAX_CHARS + 1);

   localparam logic [CHAR_WIDTH-1:0] ASCII_SPACE = 6'd32;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0] ASCII_POINT = 6'd46;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = 6'd57;

   localparam logic [7:0] SAT_LIMIT = 8'd100;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_UNS8      = 3'd0,
      CMD_UNS16     = 3'd1,
      CMD_SIGNED16  = 3'd2,
      CMD_TENTHS    = 3'd3,
      CMD_TWO_DIGIT = 3'd4
   } command_type;

   typedef struct packed {
      command_type            cmd;
      logic                   neg;
      logic                   sat;
      logic [VALUE_WIDTH-1:0] bin;
      logic [BCD_WIDTH-1:0]   bcd;
   } item_type;

   typedef logic [CHAR_WIDTH-1:0] char_type;

   // One shift-and-add-3 step of binary to BCD conversion.
   function automatic item_type dabble_step(input item_type cur);
      item_type             nxt;
      logic [BCD_WIDTH-1:0] adj;
      nxt = cur;
      adj = cur.bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      nxt.bcd = {adj[BCD_WIDTH-2:0], cur.bin[VALUE_WIDTH-1]};
      nxt.bin = {cur.bin[VALUE_WIDTH-2:0], 1'b0};
      return nxt;
   endfunction

   function automatic char_type digit_char(input logic [3:0] d);
      return ASCII_ZERO + {2'b00, d};
   endfunction

endpackage
`default_nettype wire

/* rtl/bdaf_cell.sv */
// One conversion cell: registers an item and applies one BCD shift step.
`default_nettype none
module bdaf_cell
   import bdaf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     up_valid,
   input  wire item_type up_item,
   output logic          up_hold,
   output logic          dn_valid,
   output item_type      dn_item,
   input  wire logic     dn_hold
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign take    = !valid_ff || !dn_hold;
   assign up_hold = valid_ff && dn_hold;

   always_comb begin
      valid_in = take ? up_valid : valid_ff;
      item_in  = (take && up_valid) ? dabble_step(up_item) : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule
`default_nettype wire

/* rtl/bdaf_emit.sv */
// Character builder and output buffer: lays out one run and sends it a character at a time.
`default_nettype none
module bdaf_emit
   import bdaf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire item_type  in_item,
   output logic           in_hold,
   output logic           out_valid,
   output logic [CHAR_WIDTH-1:0] out_character,
   output logic           out_last,
   input  wire logic      out_stall
);

   char_type               text_ff [MAX_CHARS];
   char_type               text_new [MAX_CHARS];
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] k;
   logic [3:0]             dig [BCD_DIGITS];
   logic [2:0]             lz;
   logic [1:0]             lzw;
   logic                   lead;
   logic                   free;
   logic                   load;

   assign free    = (count_ff == '0) || (count_ff == COUNT_WIDTH'(1) && !out_stall);
   assign in_hold = !free;
   assign load    = in_valid && free;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         dig[i] = in_item.bcd[4*(BCD_DIGITS-1-i) +: 4];
      end
      lz   = '0;
      lead = 1'b1;
      for (int i = 0; i < BCD_DIGITS - 1; i++) begin
         if (lead && dig[i] == 4'd0) begin
            lz = lz + 3'd1;
         end else begin
            lead = 1'b0;
         end
      end
      lzw  = '0;
      lead = 1'b1;
      for (int i = 0; i < BCD_DIGITS - 2; i++) begin
         if (lead && dig[i] == 4'd0) begin
            lzw = lzw + 2'd1;
         end else begin
            lead = 1'b0;
         end
      end

      for (int i = 0; i < MAX_CHARS; i++) begin
         text_new[i] = ASCII_SPACE;
      end
      k = '0;
      case (in_item.cmd)
         CMD_UNS8, CMD_UNS16, CMD_SIGNED16: begin
            if (in_item.neg) begin
               text_new[k] = ASCII_MINUS;
               k = k + COUNT_WIDTH'(1);
            end
            for (int i = 0; i < BCD_DIGITS; i++) begin
               if (3'(i) >= lz) begin
                  text_new[k] = digit_char(dig[i]);
                  k = k + COUNT_WIDTH'(1);
               end
            end
         end
         CMD_TENTHS: begin
            if (lzw == 2'd3) begin
               text_new[k] = ASCII_SPACE;
               k = k + COUNT_WIDTH'(1);
            end
            for (int i = 0; i < BCD_DIGITS - 1; i++) begin
               if (2'(i) >= lzw) begin
                  text_new[k] = digit_char(dig[i]);
                  k = k + COUNT_WIDTH'(1);
               end
            end
            text_new[k] = ASCII_POINT;
            k = k + COUNT_WIDTH'(1);
            text_new[k] = digit_char(dig[BCD_DIGITS-1]);
            k = k + COUNT_WIDTH'(1);
         end
         CMD_TWO_DIGIT: begin
            if (in_item.sat) begin
               text_new[0] = ASCII_NINE;
               text_new[1] = ASCII_NINE;
            end else begin
               text_new[0] = digit_char(dig[BCD_DIGITS-2]);
               text_new[1] = digit_char(dig[BCD_DIGITS-1]);
            end
            k = COUNT_WIDTH'(2);
         end
         default: begin
            k = '0;
         end
      endcase

      count_in = count_ff;
      if (load) begin
         count_in = k;
      end else if (count_ff != '0 && !out_stall) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         text_ff <= text_new;
      end else if (count_ff != '0 && !out_stall) begin
         for (int i = 0; i < MAX_CHARS - 1; i++) begin
            text_ff[i] <= text_ff[i+1];
         end
      end
   end

   assign out_valid     = count_ff != '0;
   assign out_character = text_ff[0];
   assign out_last      = count_ff == COUNT_WIDTH'(1);

endmodule
`default_nettype wire

/* rtl/binary_to_decimal_ascii_formatter.sv */
// Top level of the decimal ASCII formatter: input prep, conversion row and output buffer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_command, req_value
//   rsp      out        rsp_valid / rsp_stall  rsp_character, rsp_last
//
// An item passes a row of 16 registered conversion cells, then the output buffer.
// The buffer sends one character per cycle while rsp_stall is low; a run has 1 to 6 characters,
// and the next item loads as the last character of a run leaves; the row holds 16 items.
// Reset clears the valid bits of the row and the buffer's character count.
// A stall on rsp backs up through the row; req_stall rises when the first cell is full and held.
// Items with unused command codes are taken and dropped.
`default_nettype none
`include "binary_to_decimal_ascii_formatter_macros.svh"
module binary_to_decimal_ascii_formatter
   import bdaf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [CMD_WIDTH-1:0]   req_command,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [CHAR_WIDTH-1:0]       rsp_character,
   output logic                        rsp_last
);

   localparam int CELLS = VALUE_WIDTH;

   logic     cell_valid [CELLS+1];
   item_type cell_item  [CELLS+1];
   logic     cell_hold  [CELLS+1];
   item_type prep_item;
   logic     cmd_ok;

   always_comb begin
      prep_item.cmd = command_type'(req_command);
      prep_item.neg = 1'b0;
      prep_item.sat = req_value[7:0] >= SAT_LIMIT;
      prep_item.bin = req_value;
      prep_item.bcd = '0;
      cmd_ok        = 1'b1;
      case (command_type'(req_command))
         CMD_UNS8, CMD_TWO_DIGIT: begin
            prep_item.bin = {8'd0, req_value[7:0]};
         end
         CMD_UNS16, CMD_TENTHS: begin
            prep_item.bin = req_value;
         end
         CMD_SIGNED16: begin
            prep_item.neg = req_value[VALUE_WIDTH-1];
            if (req_value[VALUE_WIDTH-1]) begin
               prep_item.bin = (~req_value) + 16'd1;
            end
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
   end

   assign cell_valid[0] = req_valid && cmd_ok;
   assign cell_item[0]  = prep_item;
   assign req_stall     = cell_hold[0];

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      bdaf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[g]),
         .up_item  (cell_item[g]),
         .up_hold  (cell_hold[g]),
         .dn_valid (cell_valid[g+1]),
         .dn_item  (cell_item[g+1]),
         .dn_hold  (cell_hold[g+1])
      );
   end

   bdaf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cell_valid[CELLS]),
      .in_item       (cell_item[CELLS]),
      .in_hold       (cell_hold[CELLS]),
      .out_valid     (rsp_valid),
      .out_character (rsp_character),
      .out_last      (rsp_last),
      .out_stall     (rsp_stall)
   );

   `BDAF_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   `BDAF_ASSERT_NEXT(a_minus_then_digit, clock, reset,
      rsp_valid && !rsp_stall && rsp_character == ASCII_MINUS,
      rsp_valid && rsp_character != ASCII_MINUS && rsp_character != ASCII_POINT)
   `BDAF_ASSERT_NEXT(a_point_then_last, clock, reset,
      rsp_valid && !rsp_stall && rsp_character == ASCII_POINT, rsp_valid && rsp_last)
   `BDAF_ASSERT_SAME(a_space_not_last, clock, reset,
      rsp_valid && rsp_character == ASCII_SPACE, !rsp_last)

endmodule
`default_nettype wire
